// ===== src/stereo_linear_triangulation_assert.svh =====
// ---------------------------------------------------------------------------
// stereo_linear_triangulation_assert.svh
// assertion macros for the triangulation block, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef STEREO_LINEAR_TRIANGULATION_ASSERT_SVH
`define STEREO_LINEAR_TRIANGULATION_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define SLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define SLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLT_ASSERT(lbl, prop, msg)
`define SLT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/slt_pkg.sv =====
// ---------------------------------------------------------------------------
// slt_pkg
// widths, latencies, status codes and payload types of the triangulation block
// ---------------------------------------------------------------------------
package slt_pkg;

  localparam int CW        = 21;             // projection coefficient
  localparam int UW        = 15;             // image coordinate
  localparam int CFB       = 4;              // coordinate fraction bits
  localparam int OUT_FRAC  = 8;              // output fraction bits
  localparam int QW        = 32;             // output coordinate
  localparam int AW        = UW + CW + 2;    // row of the linear system
  localparam int EW        = 2 * AW + 2;     // normal equation entry
  localparam int DW        = 3 * EW + 3;     // determinant
  localparam int CHUNK     = 16;             // multiplier digit per stage
  localparam int NREG      = 8;
  localparam int RIW       = $clog2(NREG);
  localparam int IDXW      = 4;
  localparam int CFG_DW    = 64;
  localparam int WORDW     = 3 * CW;

  localparam int MUL_A_LAT = (AW + CHUNK - 1) / CHUNK;
  localparam int MUL_E_LAT = (EW + CHUNK - 1) / CHUNK;
  localparam int MUL_T_LAT = (2 * EW + 1 + CHUNK - 1) / CHUNK;
  localparam int DET_LAT   = MUL_E_LAT + MUL_T_LAT + 2;
  localparam int DIV_LAT   = QW + 2;

  localparam logic signed [QW-1:0] NONE_VAL = QW'(-(1 << OUT_FRAC));

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_SING = 2'd2,
    ST_SAT  = 2'd3
  } slt_status_t;

  typedef struct packed {
    logic [UW-1:0] left_x;
    logic [UW-1:0] left_y;
    logic          left_found;
    logic [UW-1:0] right_x;
    logic [UW-1:0] right_y;
    logic          right_found;
  } slt_in_t;

  typedef struct packed {
    logic signed [QW-1:0] world_x;
    logic signed [QW-1:0] world_y;
    logic signed [QW-1:0] world_z;
    slt_status_t          status;
  } slt_out_t;

endpackage

// ===== src/slt_mul.sv =====
// ---------------------------------------------------------------------------
// slt_mul
// pipelined signed multiplier, one digit of b per stage
// ---------------------------------------------------------------------------
module slt_mul import slt_pkg::*; #(
  parameter int WA = AW,
  parameter int WB = AW,
  parameter int CH = CHUNK
) (
  input  logic                    clk,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NST = (WB + CH - 1) / CH;
  localparam int PW  = WA + WB;
  localparam int BP  = NST * CH;
  localparam int TW  = WA + CH + 1;

  logic signed [WA-1:0] a_q   [NST+1];
  logic signed [BP-1:0] b_q   [NST+1];
  logic signed [PW-1:0] acc_q [NST+1];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic signed [WA-1:0] a_i;
    logic signed [BP-1:0] b_i;
    logic signed [PW-1:0] acc_i;
    logic signed [CH:0]   dig;
    logic signed [TW-1:0] term;
    logic signed [PW-1:0] term_x;

    if (s == 0) begin : g_first
      assign a_i   = a;
      assign b_i   = BP'(b);
      assign acc_i = '0;
    end else begin : g_rest
      assign a_i   = a_q[s];
      assign b_i   = b_q[s];
      assign acc_i = acc_q[s];
    end

    // top digit carries the sign, lower digits are unsigned
    if (s == NST - 1) begin : g_top
      assign dig = {b_i[BP-1], b_i[s*CH +: CH]};
    end else begin : g_low
      assign dig = {1'b0, b_i[s*CH +: CH]};
    end

    assign term   = a_i * dig;
    assign term_x = PW'(term) <<< (s * CH);

    always_ff @(posedge clk) begin
      acc_q[s+1] <= acc_i + term_x;
    end

    if (s < NST - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        a_q[s+1] <= a_i;
        b_q[s+1] <= b_i;
      end
    end
  end

  assign p = acc_q[NST];

endmodule

// ===== src/slt_det3.sv =====
// ---------------------------------------------------------------------------
// slt_det3
// pipelined 3x3 determinant of three columns by cofactor expansion
// ---------------------------------------------------------------------------
module slt_det3 import slt_pkg::*; #(
  parameter int W = EW
) (
  input  logic                   clk,
  input  logic signed [W-1:0]    c0 [3],
  input  logic signed [W-1:0]    c1 [3],
  input  logic signed [W-1:0]    c2 [3],
  output logic signed [3*W+2:0]  det
);

  localparam int TWD = 2 * W + 1;
  localparam int PWD = 3 * W + 1;
  localparam int L1  = (W + CHUNK - 1) / CHUNK;

  logic signed [2*W-1:0] pa [3];
  logic signed [2*W-1:0] pb [3];
  logic signed [TWD-1:0] t_q [3];
  logic signed [PWD-1:0] pq [3];
  logic signed [W-1:0]   dl0 [L1+1];
  logic signed [W-1:0]   dl1 [L1+1];
  logic signed [W-1:0]   dl2 [L1+1];

  // 2x2 minors of rows 1 and 2
  slt_mul #(.WA(W), .WB(W)) u_m0a (.clk(clk), .a(c1[1]), .b(c2[2]), .p(pa[0]));
  slt_mul #(.WA(W), .WB(W)) u_m0b (.clk(clk), .a(c2[1]), .b(c1[2]), .p(pb[0]));
  slt_mul #(.WA(W), .WB(W)) u_m1a (.clk(clk), .a(c0[1]), .b(c2[2]), .p(pa[1]));
  slt_mul #(.WA(W), .WB(W)) u_m1b (.clk(clk), .a(c2[1]), .b(c0[2]), .p(pb[1]));
  slt_mul #(.WA(W), .WB(W)) u_m2a (.clk(clk), .a(c0[1]), .b(c1[2]), .p(pa[2]));
  slt_mul #(.WA(W), .WB(W)) u_m2b (.clk(clk), .a(c1[1]), .b(c0[2]), .p(pb[2]));

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      t_q[k] <= TWD'(pa[k]) - TWD'(pb[k]);
    end
    dl0[0] <= c0[0];
    dl1[0] <= c1[0];
    dl2[0] <= c2[0];
    for (int k = 1; k < L1 + 1; k++) begin
      dl0[k] <= dl0[k-1];
      dl1[k] <= dl1[k-1];
      dl2[k] <= dl2[k-1];
    end
  end

  // top row times its minors
  slt_mul #(.WA(W), .WB(TWD)) u_p0 (.clk(clk), .a(dl0[L1]), .b(t_q[0]), .p(pq[0]));
  slt_mul #(.WA(W), .WB(TWD)) u_p1 (.clk(clk), .a(dl1[L1]), .b(t_q[1]), .p(pq[1]));
  slt_mul #(.WA(W), .WB(TWD)) u_p2 (.clk(clk), .a(dl2[L1]), .b(t_q[2]), .p(pq[2]));

  always_ff @(posedge clk) begin
    det <= (3*W+3)'(pq[0]) - (3*W+3)'(pq[1]) + (3*W+3)'(pq[2]);
  end

endmodule

// ===== src/slt_div.sv =====
// ---------------------------------------------------------------------------
// slt_div
// pipelined rounded quotient num * 2^8 / den, one quotient bit per stage
// ---------------------------------------------------------------------------
module slt_div import slt_pkg::*; #(
  parameter int NW = DW
) (
  input  logic                 clk,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic signed [QW-1:0] q,
  output logic                 sat
);

  localparam int RW = NW + QW + 2;
  localparam int DDW = NW + 1;

  logic [NW-1:0]  an;
  logic [NW-1:0]  ad;
  logic [RW-1:0]  rem_in;
  logic [DDW-1:0] dd_in;
  logic           big_in;

  logic [RW-1:0]  rem_q [QW+1];
  logic [QW-1:0]  quo_q [QW+1];
  logic           neg_q [QW+1];
  logic [DDW-1:0] dd_q  [QW];
  logic           big_q [QW];

  // magnitudes; half of the divisor added for round to nearest
  assign an     = num[NW-1] ? NW'(-num) : NW'(num);
  assign ad     = den[NW-1] ? NW'(-den) : NW'(den);
  assign rem_in = (RW'(an) << (OUT_FRAC + 1)) + RW'(ad);
  assign dd_in  = {ad, 1'b0};
  assign big_in = rem_in >= (RW'(dd_in) << QW);

  always_ff @(posedge clk) begin
    rem_q[0] <= rem_in;
    dd_q[0]  <= dd_in;
    big_q[0] <= big_in;
    neg_q[0] <= num[NW-1] ^ den[NW-1];
    quo_q[0] <= big_in ? '1 : '0;
  end

  for (genvar s = 0; s < QW; s++) begin : g_bit
    localparam int BI = QW - 1 - s;
    logic [RW-1:0] shd;
    logic          take;
    assign shd  = RW'(dd_q[s]) << BI;
    assign take = !big_q[s] && (rem_q[s] >= shd);

    always_ff @(posedge clk) begin
      rem_q[s+1] <= take ? rem_q[s] - shd : rem_q[s];
      quo_q[s+1] <= quo_q[s] | (take ? (QW'(1) << BI) : '0);
      neg_q[s+1] <= neg_q[s];
    end

    if (s < QW - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        dd_q[s+1]  <= dd_q[s];
        big_q[s+1] <= big_q[s];
      end
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (neg_q[QW]) begin
      if (quo_q[QW] > {1'b1, {(QW-1){1'b0}}}) begin
        q   <= {1'b1, {(QW-1){1'b0}}};
        sat <= 1'b1;
      end else begin
        q   <= -quo_q[QW];
        sat <= 1'b0;
      end
    end else begin
      if (quo_q[QW][QW-1]) begin
        q   <= {1'b0, {(QW-1){1'b1}}};
        sat <= 1'b1;
      end else begin
        q   <= quo_q[QW];
        sat <= 1'b0;
      end
    end
  end

endmodule

// ===== src/stereo_linear_triangulation.sv =====
// ---------------------------------------------------------------------------
// stereo_linear_triangulation
// two-view linear least-squares triangulation through exact normal equations
// ---------------------------------------------------------------------------
//  channel   ports                                   transfer when
//  item in   start, busy, item                       start && !busy
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//  result    done, result                            done (one cycle, no stall)
//
//  one item per cycle out of reset; the result strobe follows the item
//  transfer through the chunked multipliers of the determinant units
//  and the 32-stage quotient pipeline
//  rst is synchronous; busy is high only while rst is high
//  the pipeline never stalls since the result side cannot hold off
// ---------------------------------------------------------------------------
`include "stereo_linear_triangulation_assert.svh"

module stereo_linear_triangulation import slt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  slt_in_t         item,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [IDXW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output logic            done,
  output slt_out_t        result
);

  localparam int ML  = MUL_A_LAT;
  localparam int DL  = DET_LAT;
  localparam int VL  = DIV_LAT;
  localparam int TOT = 4 + ML + DL + VL;
  localparam int UPW = UW + CW + 1;

  // pair table for the normal equations: six entries of A^T A, three of A^T b
  localparam int PI [9] = '{0, 0, 0, 1, 1, 2, 0, 1, 2};
  localparam int PJ [9] = '{0, 1, 2, 1, 2, 2, 0, 0, 0};

  localparam logic signed [UW:0] U_MISS = (UW+1)'(-(1 << CFB));

  logic               acc;
  logic [WORDW-1:0]   proj [NREG];
  logic signed [CW-1:0] cf [2][12];

  slt_in_t            in_q;
  logic signed [UW:0] u [4];
  logic signed [UPW-1:0] up_a [4][3];
  logic signed [UPW-1:0] up_b [4];
  logic signed [AW-1:0]  a_d [4][3];
  logic signed [AW-1:0]  b_d [4];
  logic signed [AW-1:0]  a_q [4][3];
  logic signed [AW-1:0]  b_q [4];

  logic signed [2*AW-1:0] prod [4][9];
  logic signed [EW-1:0]   ne_q [9];
  logic signed [EW-1:0]   col0 [3];
  logic signed [EW-1:0]   col1 [3];
  logic signed [EW-1:0]   col2 [3];
  logic signed [EW-1:0]   cv   [3];

  logic signed [DW-1:0] d_det;
  logic signed [DW-1:0] n_det [3];
  logic signed [QW-1:0] qv [3];
  logic                 sv [3];

  logic [TOT-2:0] vpipe;
  logic [TOT-2:0] nf_pipe;
  logic [VL-1:0]  dz_pipe;

  // input handshake: every cycle out of reset
  assign busy = rst;
  assign acc  = start && !busy;

  // configuration registers, writes past the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NREG; k++) begin
        proj[k] <= '0;
      end
    end else if (cfg_valid && (cfg_index < IDXW'(NREG))) begin
      proj[cfg_index[RIW-1:0]] <= cfg_data[WORDW-1:0];
    end
  end

  // unpack the two 3x4 matrices, row-major, three fields per word
  for (genvar g = 0; g < 24; g++) begin : g_cf
    localparam int CAM = g / 12;
    localparam int IX  = g % 12;
    localparam int WI  = CAM * 4 + IX / 3;
    localparam int FI  = IX % 3;
    assign cf[CAM][IX] = proj[WI][FI*CW +: CW];
  end

  // stage 0: item register
  always_ff @(posedge clk) begin
    if (acc) begin
      in_q <= item;
    end
  end

  // a missing point takes part with both coordinates at -1.0
  assign u[0] = in_q.left_found  ? {1'b0, in_q.left_x}  : U_MISS;
  assign u[1] = in_q.left_found  ? {1'b0, in_q.left_y}  : U_MISS;
  assign u[2] = in_q.right_found ? {1'b0, in_q.right_x} : U_MISS;
  assign u[3] = in_q.right_found ? {1'b0, in_q.right_y} : U_MISS;

  // stage 1: rows of the 4x3 system and right-hand side
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 3; j++) begin
        up_a[r][j] = u[r] * cf[r >> 1][8 + j];
        a_d[r][j]  = AW'(up_a[r][j]) - (AW'(cf[r >> 1][(r & 1) * 4 + j]) <<< CFB);
      end
      up_b[r] = u[r] * cf[r >> 1][11];
      b_d[r]  = (AW'(cf[r >> 1][(r & 1) * 4 + 3]) <<< CFB) - AW'(up_b[r]);
    end
  end

  always_ff @(posedge clk) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  // products for A^T A and A^T b
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar pp = 0; pp < 9; pp++) begin : g_pair
      logic signed [AW-1:0] opb;
      if (pp < 6) begin : g_aa
        assign opb = a_q[r][PJ[pp]];
      end else begin : g_ab
        assign opb = b_q[r];
      end
      slt_mul #(.WA(AW), .WB(AW)) u_mul (
        .clk (clk),
        .a   (a_q[r][PI[pp]]),
        .b   (opb),
        .p   (prod[r][pp])
      );
    end
  end

  // sum over the four rows
  always_ff @(posedge clk) begin
    for (int pp = 0; pp < 9; pp++) begin
      ne_q[pp] <= EW'(prod[0][pp]) + EW'(prod[1][pp]) + EW'(prod[2][pp]) + EW'(prod[3][pp]);
    end
  end

  // columns of the symmetric normal matrix and the right-hand column
  assign col0[0] = ne_q[0];
  assign col0[1] = ne_q[1];
  assign col0[2] = ne_q[2];
  assign col1[0] = ne_q[1];
  assign col1[1] = ne_q[3];
  assign col1[2] = ne_q[4];
  assign col2[0] = ne_q[2];
  assign col2[1] = ne_q[4];
  assign col2[2] = ne_q[5];
  assign cv[0]   = ne_q[6];
  assign cv[1]   = ne_q[7];
  assign cv[2]   = ne_q[8];

  // cramer's rule: the system determinant and one per coordinate
  slt_det3 #(.W(EW)) u_det_d (.clk(clk), .c0(col0), .c1(col1), .c2(col2), .det(d_det));
  slt_det3 #(.W(EW)) u_det_x (.clk(clk), .c0(cv),   .c1(col1), .c2(col2), .det(n_det[0]));
  slt_det3 #(.W(EW)) u_det_y (.clk(clk), .c0(col0), .c1(cv),   .c2(col2), .det(n_det[1]));
  slt_det3 #(.W(EW)) u_det_z (.clk(clk), .c0(col0), .c1(col1), .c2(cv),   .det(n_det[2]));

  for (genvar k = 0; k < 3; k++) begin : g_div
    slt_div #(.NW(DW)) u_div (
      .clk (clk),
      .num (n_det[k]),
      .den (d_det),
      .q   (qv[k]),
      .sat (sv[k])
    );
  end

  // valid and side flags travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      done  <= 1'b0;
    end else begin
      vpipe <= {vpipe[TOT-3:0], acc};
      done  <= vpipe[TOT-2];
    end
  end

  always_ff @(posedge clk) begin
    nf_pipe <= {nf_pipe[TOT-3:0], !item.left_found && !item.right_found};
    dz_pipe <= {dz_pipe[VL-2:0], d_det == '0};
  end

  // output register: no point, singular, or the three quotients
  always_ff @(posedge clk) begin
    if (nf_pipe[TOT-2]) begin
      result.world_x <= NONE_VAL;
      result.world_y <= NONE_VAL;
      result.world_z <= NONE_VAL;
      result.status  <= ST_NONE;
    end else if (dz_pipe[VL-1]) begin
      result.world_x <= '0;
      result.world_y <= '0;
      result.world_z <= '0;
      result.status  <= ST_SING;
    end else begin
      result.world_x <= qv[0];
      result.world_y <= qv[1];
      result.world_z <= qv[2];
      result.status  <= (sv[0] || sv[1] || sv[2]) ? ST_SAT : ST_OK;
    end
  end

  // checks
  `SLT_ASSERT(a_none_found, done && result.status == ST_NONE |-> result.world_x == NONE_VAL && result.world_y == NONE_VAL && result.world_z == NONE_VAL, "no-point result not -1")
  `SLT_ASSERT(a_singular_zero, done && result.status == ST_SING |-> result.world_x == 0 && result.world_y == 0 && result.world_z == 0, "singular result not zero")
  `SLT_ASSERT_ALWAYS(a_reset_quiet, rst |=> !done, "result strobe after reset")

endmodule

// ===== sim/stereo_linear_triangulation_test.sv =====
// ---------------------------------------------------------------------------
// stereo_linear_triangulation_test
// self-checking bench for the stereo triangulation block: a directed table
// and then random point pairs under changing projection matrices, each
// result checked field by field against a table value or an exact wide-integer solver
// ---------------------------------------------------------------------------
module stereo_linear_triangulation_test;
  import slt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // exact arithmetic in 320-bit signed integers, wider than the block's determinant
  typedef logic signed [319:0] wide_t;

  typedef struct {
    slt_in_t  pts;
    bit       known;
    slt_out_t want;
  } point_row_t;

  localparam int DRAIN_CYCLES = 70;     // result latency plus margin
  localparam int STALL_LIMIT  = 4000;   // cycles with no transfer at all

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  slt_in_t           item;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDXW-1:0]   cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic              done;
  slt_out_t          result;

  // shadow copy of the projection registers
  logic [WORDW-1:0] proj_words [NREG];

  // points still in flight, oldest first
  slt_out_t pending_points [$];

  int failures;
  int points_sent;
  int points_checked;
  int cfg_writes;
  int idle_pct;
  int stall_cycles;

  stereo_linear_triangulation i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // solver
  // ---------------------------------------------------------------------

  // signed 21-bit coefficient idx (row-major) of camera cam
  function automatic longint proj_coef(int cam, int idx);
    logic signed [CW-1:0] f;
    f = proj_words[cam * 4 + idx / 3] >> (CW * (idx % 3));
    return longint'(f);
  endfunction

  // determinant of a 3x3 matrix held as columns m[col][row]
  function automatic wide_t det3(wide_t m [3][3]);
    wide_t t0, t1, t2;
    t0 = m[1][1] * m[2][2] - m[2][1] * m[1][2];
    t1 = m[0][1] * m[2][2] - m[2][1] * m[0][2];
    t2 = m[0][1] * m[1][2] - m[1][1] * m[0][2];
    return m[0][0] * t0 - m[1][0] * t1 + m[2][0] * t2;
  endfunction

  // num / den with 8 fraction bits, rounded half away from zero, saturated
  function automatic logic [QW-1:0] scaled_quotient(wide_t num, wide_t den,
                                                    inout bit sat);
    bit          neg;
    logic [319:0] an, ad, nn, dv;
    logic [63:0]  q;
    neg = (num < 0) != (den < 0);
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    nn  = (an << (OUT_FRAC + 1)) + ad;
    dv  = ad << 1;
    if (nn >= (dv << 32)) q = 64'hFFFF_FFFF;
    else q = 64'(nn / dv);
    if (neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return 32'(q);
  endfunction

  // least-squares 3d point from two image points
  function automatic slt_out_t triangulate(slt_in_t p);
    longint   one;
    longint   u [4];
    longint   arow, brow;
    wide_t    a [4][3];
    wide_t    b [4];
    wide_t    ata [3][3];
    wide_t    atb [3];
    wide_t    cram [3][3];
    wide_t    den;
    logic [QW-1:0] q [3];
    bit       sat;
    slt_out_t r;
    one = longint'(1) << CFB;
    sat = 1'b0;
    if (!p.left_found && !p.right_found) begin
      r.world_x = NONE_VAL;
      r.world_y = NONE_VAL;
      r.world_z = NONE_VAL;
      r.status  = ST_NONE;
      return r;
    end
    // a missing point enters the system at (-1, -1)
    u[0] = p.left_found  ? longint'(p.left_x)  : -one;
    u[1] = p.left_found  ? longint'(p.left_y)  : -one;
    u[2] = p.right_found ? longint'(p.right_x) : -one;
    u[3] = p.right_found ? longint'(p.right_y) : -one;
    for (int r4 = 0; r4 < 4; r4++) begin
      for (int j = 0; j < 3; j++) begin
        arow = u[r4] * proj_coef(r4 / 2, 8 + j)
             - proj_coef(r4 / 2, (r4 % 2) * 4 + j) * one;
        a[r4][j] = arow;
      end
      brow = proj_coef(r4 / 2, (r4 % 2) * 4 + 3) * one - u[r4] * proj_coef(r4 / 2, 11);
      b[r4] = brow;
    end
    // normal equations, ata[j][i] is column j
    for (int i = 0; i < 3; i++) begin
      atb[i] = '0;
      for (int j = 0; j < 3; j++) ata[j][i] = '0;
      for (int r4 = 0; r4 < 4; r4++) begin
        atb[i] += a[r4][i] * b[r4];
        for (int j = 0; j < 3; j++) ata[j][i] += a[r4][i] * a[r4][j];
      end
    end
    den = det3(ata);
    if (den == 0) begin
      r.world_x = '0;
      r.world_y = '0;
      r.world_z = '0;
      r.status  = ST_SING;
      return r;
    end
    // cramer's rule, one column swapped for A^T b
    for (int k = 0; k < 3; k++) begin
      cram = ata;
      cram[k] = atb;
      q[k] = scaled_quotient(det3(cram), den, sat);
    end
    r.world_x = q[0];
    r.world_y = q[1];
    r.world_z = q[2];
    r.status  = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // one point pair transfer, then maybe a random gap
  task automatic send_points(slt_in_t p, bit known, slt_out_t want);
    start <= 1'b1;
    item  <= p;
    do @(posedge clk); while (busy);
    pending_points.push_back(known ? want : triangulate(p));
    points_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // block goes idle: every point back, then the pipeline flushed
  task automatic drain_points();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid stays high between back-to-back writes, the caller drops it
  task automatic write_reg(logic [IDXW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NREG) proj_words[idx] = val[WORDW-1:0];
    cfg_writes++;
  endtask

  function automatic logic [CFG_DW-1:0] pack_word(longint c0, longint c1, longint c2);
    logic [CW-1:0] f0, f1, f2;
    f0 = c0[CW-1:0];
    f1 = c1[CW-1:0];
    f2 = c2[CW-1:0];
    // bit 63 is dropped by the block, so it gets noise
    return {1'($urandom_range(1)), f2, f1, f0};
  endfunction

  function automatic longint rand_coef(int lim);
    return longint'($urandom_range(2 * lim)) - lim;
  endfunction

  // load both matrices; kind picks the flavor of coefficients
  task automatic load_cameras(int kind);
    longint c [12];
    for (int cam = 0; cam < 2; cam++) begin
      for (int k = 0; k < 12; k++) begin
        case (kind)
          0: c[k] = 0;
          1: c[k] = (1 << (CW - 1)) - 1;                 // max positive
          2: c[k] = -(1 << (CW - 1));                    // most negative
          3: c[k] = rand_coef((1 << (CW - 1)) - 1);      // full range
          4: c[k] = (k % 2) ? (1 << (CW - 1)) - 1 : -(1 << (CW - 1));
          default: c[k] = (k < 8) ? rand_coef(3000) : rand_coef(40);  // camera-like
        endcase
      end
      for (int w = 0; w < 4; w++)
        write_reg(IDXW'(cam * 4 + w), pack_word(c[3 * w], c[3 * w + 1], c[3 * w + 2]));
    end
    // an index past the register file, ignored
    write_reg(IDXW'($urandom_range(NREG, 15)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  function automatic slt_in_t rand_points();
    slt_in_t p;
    p.left_x  = UW'($urandom);
    p.left_y  = UW'($urandom);
    p.right_x = UW'($urandom);
    p.right_y = UW'($urandom);
    // mostly both views found, the rest with each view found at random
    if ($urandom_range(99) < 80) begin
      p.left_found  = 1'b1;
      p.right_found = 1'b1;
    end else begin
      p.left_found  = 1'($urandom);
      p.right_found = 1'($urandom);
    end
    return p;
  endfunction

  function automatic slt_in_t make_points(int lx, int ly, bit lf, int rx, int ry, bit rf);
    slt_in_t p;
    p.left_x      = UW'(lx);
    p.left_y      = UW'(ly);
    p.left_found  = lf;
    p.right_x     = UW'(rx);
    p.right_y     = UW'(ry);
    p.right_found = rf;
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // result check: every strobe pops the oldest expected point
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    slt_out_t want;
    if (!rst && done) begin
      if (pending_points.size() == 0) begin
        $error("result with no point pair in flight");
        failures++;
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (result.world_x !== want.world_x) begin
          $error("world_x expected %0d actual %0d", want.world_x, result.world_x);
          failures++;
        end
        if (result.world_y !== want.world_y) begin
          $error("world_y expected %0d actual %0d", want.world_y, result.world_y);
          failures++;
        end
        if (result.world_z !== want.world_z) begin
          $error("world_z expected %0d actual %0d", want.world_z, result.world_z);
          failures++;
        end
        if (result.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, result.status);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    point_row_t table_rows [$];
    point_row_t row;
    slt_out_t   none_out, sing_out, any_out;
    int         max_c;

    failures       = 0;
    points_sent    = 0;
    points_checked = 0;
    cfg_writes     = 0;
    stall_cycles   = 0;
    idle_pct       = 10;
    foreach (proj_words[i]) proj_words[i] = '0;
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    none_out = '{world_x: NONE_VAL, world_y: NONE_VAL, world_z: NONE_VAL, status: ST_NONE};
    sing_out = '{world_x: '0, world_y: '0, world_z: '0, status: ST_SING};
    any_out  = '0;
    max_c    = (1 << UW) - 1;

    // directed, reset matrices: all zero so any found point is singular
    table_rows.push_back('{make_points(0, 0, 0, 0, 0, 0), 1'b1, none_out});
    table_rows.push_back('{make_points(max_c, max_c, 0, max_c, max_c, 0), 1'b1, none_out});
    table_rows.push_back('{make_points(0, 0, 1, 0, 0, 1), 1'b1, sing_out});
    table_rows.push_back('{make_points(max_c, max_c, 1, max_c, max_c, 1), 1'b1, sing_out});
    table_rows.push_back('{make_points(100, 200, 1, 0, 0, 0), 1'b1, sing_out});
    table_rows.push_back('{make_points(0, 0, 0, 300, 400, 1), 1'b1, sing_out});
    foreach (table_rows[i])
      send_points(table_rows[i].pts, table_rows[i].known, table_rows[i].want);
    drain_points();

    // directed, camera-like matrices: extremes, one view or both missing
    load_cameras(5);
    table_rows.delete();
    table_rows.push_back('{make_points(0, 0, 1, 0, 0, 1), 1'b0, any_out});
    table_rows.push_back('{make_points(max_c, max_c, 1, max_c, max_c, 1), 1'b0, any_out});
    table_rows.push_back('{make_points(max_c, 0, 1, 0, max_c, 1), 1'b0, any_out});
    table_rows.push_back('{make_points(16000, 12000, 1, 15000, 12100, 1), 1'b0, any_out});
    table_rows.push_back('{make_points(16000, 12000, 1, 0, 0, 0), 1'b0, any_out});
    table_rows.push_back('{make_points(0, 0, 0, 15000, 12100, 1), 1'b0, any_out});
    table_rows.push_back('{make_points(5, 7, 0, 9, 11, 0), 1'b1, none_out});
    foreach (table_rows[i])
      send_points(table_rows[i].pts, table_rows[i].known, table_rows[i].want);
    drain_points();

    // directed, extreme coefficients
    for (int kind = 1; kind <= 4; kind++) begin
      load_cameras(kind);
      send_points(make_points(0, 0, 1, max_c, max_c, 1), 1'b0, any_out);
      send_points(make_points(max_c, 1, 1, 1, max_c, 1), 1'b0, any_out);
      send_points(make_points(max_c, max_c, 0, 0, 0, 1), 1'b0, any_out);
      drain_points();
    end

    // random: three idling modes, four matrix settings each
    for (int setting = 0; setting < 12; setting++) begin
      idle_pct = (setting < 4) ? 10 : (setting < 8) ? 70 : 0;
      load_cameras((setting % 4 == 3) ? $urandom_range(0, 4) : 5);
      for (int n = 0; n < 95; n++) begin
        send_points(rand_points(), 1'b0, any_out);
        // hold off until the pipeline has emptied
        if (setting == 5 && n == 40) begin
          start <= 1'b0;
          while (pending_points.size() != 0) @(posedge clk);
        end
      end
      drain_points();
    end

    $display("covered %0d point pairs and %0d register writes, %0d results checked",
             points_sent, cfg_writes, points_checked);
    $display("matrices: reset, extremes, full-range random and camera-like");
    if (failures == 0 && pending_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
